// ===== sv/eht_pkg.sv =====
// Shared constants and types for the extendible hash table unit.
package eht_pkg;
  localparam int MaxDepthDef     = 8;
  localparam int InitialDepthDef = 2;
  localparam int PoolBucketsDef  = 64;
  localparam int BucketSlotsDef  = 8;
  localparam int ItemWidthDef    = 32;

  localparam int KeyWidth    = 32;
  localparam int StatusWidth = 2;
  localparam int DepthWidth  = 4;
  localparam int CapWidth    = 4;
  localparam logic [CapWidth-1:0] CapReset = 4'd4;

  typedef logic [StatusWidth-1:0] status_t;
  localparam status_t StatusInserted = 2'd0;
  localparam status_t StatusFound    = 2'd1;
  localparam status_t StatusMissing  = 2'd2;
  localparam status_t StatusFailed   = 2'd3;

  localparam logic OpInsert = 1'b0;
  localparam logic OpQuery  = 1'b1;
endpackage

// ===== sv/eht_if.sv =====
// Valid/ready channel interfaces for the input and result sides.
interface eht_in_if
  import eht_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [KeyWidth-1:0] hash_key;
  logic [31:0]         item_value;
  modport source (output valid, operation, hash_key, item_value, input ready);
  modport sink   (input valid, operation, hash_key, item_value, output ready);
endinterface

interface eht_out_if
  import eht_pkg::*;
();
  logic                  valid;
  logic                  ready;
  status_t               status;
  logic [DepthWidth-1:0] current_depth;
  modport source (output valid, status, current_depth, input ready);
  modport sink   (input valid, status, current_depth, output ready);
endinterface

// ===== sv/extendible_hash_table_unit.sv =====
// Extendible hash table unit: top level with directory, bucket memories and sequencer.
//
// One operation at a time. A query handles each slot compared through the shared slot
// memory port as a read, then a compare, and stops early on a hit. A directory doubling
// walks 2^depth slots, reading then writing each one. A split walks its shadow slots
// twice and re-appends each stored item through S_RDRD, S_RDDIR, S_RDDIR2, S_RDFILL
// and S_RDAPP. No clearing pass after reset: each directory slot has a valid bit.
module extendible_hash_table_unit
  import eht_pkg::*;
#(
  parameter int MAX_DEPTH     = MaxDepthDef,
  parameter int INITIAL_DEPTH = InitialDepthDef,
  parameter int POOL_BUCKETS  = PoolBucketsDef,
  parameter int BUCKET_SLOTS  = BucketSlotsDef,
  parameter int ITEM_WIDTH    = ItemWidthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CapWidth-1:0] cfg_wdata,
  eht_in_if.sink              in_ch,
  eht_out_if.source           out_ch
);
  localparam int DirSlots = 1 << MAX_DEPTH;
  localparam int DW  = MAX_DEPTH;
  localparam int BW  = (POOL_BUCKETS > 1) ? $clog2(POOL_BUCKETS) : 1;
  localparam int CW  = $clog2(POOL_BUCKETS + 1);
  localparam int SW  = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int FW  = $clog2(BUCKET_SLOTS + 1);
  localparam int GW  = $clog2(MAX_DEPTH + 1);
  localparam int SAW = BW + SW;
  localparam int SlotDepth = POOL_BUCKETS << SW;
  localparam int InitD = (INITIAL_DEPTH < MAX_DEPTH) ? INITIAL_DEPTH : MAX_DEPTH;
  localparam int HeldW = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int Guard = 2 * MAX_DEPTH + 4;
  localparam int GdW = $clog2(Guard + 1);

  // sequencer state codes
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DREAD   = 5'd1;
  localparam logic [4:0] S_DECIDE  = 5'd2;
  localparam logic [4:0] S_QREAD   = 5'd3;
  localparam logic [4:0] S_QCMP    = 5'd4;
  localparam logic [4:0] S_DBLRD   = 5'd5;
  localparam logic [4:0] S_DBLWR   = 5'd6;
  localparam logic [4:0] S_CHKRD   = 5'd7;
  localparam logic [4:0] S_CHKCMP  = 5'd8;
  localparam logic [4:0] S_CPYRD   = 5'd9;
  localparam logic [4:0] S_CPYWR   = 5'd10;
  localparam logic [4:0] S_ASSIGN  = 5'd11;
  localparam logic [4:0] S_RDRD    = 5'd12;
  localparam logic [4:0] S_RDDIR   = 5'd13;
  localparam logic [4:0] S_RDFILL  = 5'd14;
  localparam logic [4:0] S_RDAPP   = 5'd15;
  localparam logic [4:0] S_DONE    = 5'd16;
  localparam logic [4:0] S_DREAD2  = 5'd17;
  localparam logic [4:0] S_RDDIR2  = 5'd18;

  // memories
  logic [BW-1:0]               dir_mem [DirSlots];
  logic [DirSlots-1:0]         dir_valid_r;
  logic [GW-1:0]               ld_mem [POOL_BUCKETS];
  logic [FW-1:0]               fill_mem [POOL_BUCKETS];
  logic [KeyWidth-1:0]         key_mem [SlotDepth];
  logic [ITEM_WIDTH-1:0]       item_mem [SlotDepth];
  logic [KeyWidth-1:0]         hkey_mem [BUCKET_SLOTS];
  logic [ITEM_WIDTH-1:0]       hitem_mem [BUCKET_SLOTS];

  logic [4:0]            state_r, state_nxt;
  logic [CapWidth-1:0]   cap_r;
  logic [GW-1:0]         gd_r, gd_nxt;
  logic [CW-1:0]         alloc_r, alloc_nxt;
  logic                  op_r;
  logic [KeyWidth-1:0]   key_r;
  logic [ITEM_WIDTH-1:0] item_r;
  status_t               status_r, status_nxt;
  logic [GdW-1:0]        guard_r, guard_nxt;

  // walk registers
  logic [DW:0]           cnt_r, cnt_nxt;
  logic [DW-1:0]         idx_r, idx_nxt;
  logic [BW-1:0]         bkt_r, bkt_nxt;
  logic [GW-1:0]         ld_r, ld_nxt;
  logic [FW-1:0]         n_r, n_nxt;
  logic [FW-1:0]         j_r, j_nxt;

  // directory port
  logic                  dir_we;
  logic [DW-1:0]         dir_waddr, dir_raddr;
  logic [BW-1:0]         dir_wdata;
  logic [BW-1:0]         dir_rd_r;
  logic                  dir_rv_r;
  // bucket header port
  logic                  hdr_we;
  logic [BW-1:0]         hdr_addr;
  logic [GW-1:0]         hdr_ld_wdata;
  logic [FW-1:0]         hdr_fill_wdata;
  logic                  fill_we;
  logic [GW-1:0]         ld_rd_r;
  logic [FW-1:0]         fill_rd_r;
  // slot store port
  logic                  slot_we;
  logic [SAW-1:0]        slot_waddr, slot_raddr;
  logic [KeyWidth-1:0]   slot_wkey;
  logic [ITEM_WIDTH-1:0] slot_witem;
  logic [KeyWidth-1:0]   skey_rd_r;
  logic [ITEM_WIDTH-1:0] sitem_rd_r;
  // held copy port
  logic                  held_we;
  logic [HeldW-1:0]      held_waddr, held_raddr;
  logic [KeyWidth-1:0]   hkey_rd_r;
  logic [ITEM_WIDTH-1:0] hitem_rd_r;

  // derived values
  logic [DW-1:0]         gmask;
  logic [FW-1:0]         eff_cap;
  logic [DW:0]           stride, count;
  logic [DW-1:0]         base_idx;
  logic [DW-1:0]         walk_slot;

  always_comb begin
    gmask = DW'((DW+1)'(1) << gd_r) - DW'(1);
    if (cap_r == '0) eff_cap = FW'(1);
    else if (32'(cap_r) > BUCKET_SLOTS) eff_cap = FW'(BUCKET_SLOTS);
    else eff_cap = FW'(cap_r);
    stride   = (DW+1)'(1) << ld_r;
    count    = (DW+1)'(1) << (gd_r - ld_r);
    base_idx = idx_r & DW'(stride - 1'b1);
    walk_slot = DW'(cnt_r << ld_r) | base_idx;
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CapReset;
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  // directory memory and valid bits
  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
    dir_rd_r <= dir_mem[dir_raddr];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_valid_r <= '0;
      dir_rv_r    <= 1'b0;
    end else begin
      if (dir_we) dir_valid_r[dir_waddr] <= 1'b1;
      dir_rv_r <= dir_valid_r[dir_raddr];
    end
  end

  // bucket header memories
  always_ff @(posedge clk) begin
    if (hdr_we) ld_mem[hdr_addr] <= hdr_ld_wdata;
    if (hdr_we || fill_we) fill_mem[hdr_addr] <= hdr_fill_wdata;
    ld_rd_r   <= ld_mem[hdr_addr];
    fill_rd_r <= fill_mem[hdr_addr];
  end

  // slot store
  always_ff @(posedge clk) begin
    if (slot_we) begin
      key_mem[slot_waddr]  <= slot_wkey;
      item_mem[slot_waddr] <= slot_witem;
    end
    skey_rd_r  <= key_mem[slot_raddr];
    sitem_rd_r <= item_mem[slot_raddr];
  end

  // held copy of a splitting bucket
  always_ff @(posedge clk) begin
    if (held_we) begin
      hkey_mem[held_waddr]  <= skey_rd_r;
      hitem_mem[held_waddr] <= sitem_rd_r;
    end
    hkey_rd_r  <= hkey_mem[held_raddr];
    hitem_rd_r <= hitem_mem[held_raddr];
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    gd_nxt     = gd_r;
    alloc_nxt  = alloc_r;
    status_nxt = status_r;
    guard_nxt  = guard_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    bkt_nxt    = bkt_r;
    ld_nxt     = ld_r;
    n_nxt      = n_r;
    j_nxt      = j_r;
    dir_we     = 1'b0;
    dir_waddr  = idx_r;
    dir_wdata  = bkt_r;
    dir_raddr  = key_r[DW-1:0] & gmask;
    hdr_we     = 1'b0;
    fill_we    = 1'b0;
    hdr_addr   = bkt_r;
    hdr_ld_wdata   = gd_r;
    hdr_fill_wdata = '0;
    slot_we    = 1'b0;
    slot_waddr = {bkt_r, SW'(0)};
    slot_wkey  = key_r;
    slot_witem = item_r;
    slot_raddr = {bkt_r, j_r[SW-1:0]};
    held_we    = 1'b0;
    held_waddr = HeldW'(j_r);
    held_raddr = HeldW'(j_r);
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_DREAD;
          guard_nxt = '0;
        end
      end
      S_DREAD: begin
        // directory read issued this cycle
        idx_nxt   = key_r[DW-1:0] & gmask;
        state_nxt = S_DREAD2;
      end
      S_DREAD2: begin
        bkt_nxt   = dir_rd_r;
        hdr_addr  = dir_rd_r;
        if (!dir_rv_r) begin
          if (op_r == OpQuery) begin
            status_nxt = StatusMissing;
            state_nxt  = S_DONE;
          end else if (alloc_r >= CW'(POOL_BUCKETS)) begin
            status_nxt = StatusFailed;
            state_nxt  = S_DONE;
          end else begin
            // fresh bucket holding the new item
            bkt_nxt        = BW'(alloc_r);
            hdr_addr       = BW'(alloc_r);
            hdr_we         = 1'b1;
            hdr_fill_wdata = FW'(1);
            dir_we         = 1'b1;
            dir_wdata      = BW'(alloc_r);
            slot_we        = 1'b1;
            slot_waddr     = {BW'(alloc_r), SW'(0)};
            alloc_nxt      = alloc_r + 1'b1;
            status_nxt     = StatusInserted;
            state_nxt      = S_DONE;
          end
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        n_nxt = (32'(fill_rd_r) > BUCKET_SLOTS) ? FW'(BUCKET_SLOTS) : fill_rd_r;
        ld_nxt = ld_rd_r;
        j_nxt = '0;
        if (op_r == OpQuery) begin
          state_nxt = S_QREAD;
        end else if (fill_rd_r < eff_cap) begin
          slot_we        = 1'b1;
          slot_waddr     = {bkt_r, fill_rd_r[SW-1:0]};
          fill_we        = 1'b1;
          hdr_fill_wdata = fill_rd_r + 1'b1;
          status_nxt     = StatusInserted;
          state_nxt      = S_DONE;
        end else if (32'(guard_r) >= Guard - 1) begin
          status_nxt = StatusFailed;
          state_nxt  = S_DONE;
        end else if (ld_rd_r < gd_r) begin
          cnt_nxt   = (DW+1)'(1);
          state_nxt = S_CHKRD;
        end else if (32'(gd_r) >= MAX_DEPTH) begin
          status_nxt = StatusFailed;
          state_nxt  = S_DONE;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_DBLRD;
        end
      end
      S_QREAD: begin
        if (j_r >= n_r) begin
          status_nxt = StatusMissing;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_QCMP;
        end
      end
      S_QCMP: begin
        if (sitem_rd_r == item_r) begin
          status_nxt = StatusFound;
          state_nxt  = S_DONE;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_QREAD;
        end
      end
      // directory doubling: copy lower half upward
      S_DBLRD: begin
        dir_raddr = DW'(cnt_r);
        state_nxt = S_DBLWR;
      end
      S_DBLWR: begin
        if (dir_rv_r) begin
          dir_we    = 1'b1;
          dir_waddr = DW'(cnt_r) | DW'((DW+1)'(1) << gd_r);
          dir_wdata = dir_rd_r;
        end
        if (cnt_r == ((DW+1)'(1) << gd_r) - 1'b1) begin
          gd_nxt    = gd_r + 1'b1;
          guard_nxt = guard_r + 1'b1;
          state_nxt = S_DREAD;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_DBLRD;
        end
      end
      // split: check shadows all name the bucket
      S_CHKRD: begin
        if (cnt_r >= count) begin
          if (32'(count) - 1 > POOL_BUCKETS - 32'(alloc_r)) begin
            status_nxt = StatusFailed;
            state_nxt  = S_DONE;
          end else begin
            j_nxt     = '0;
            state_nxt = S_CPYRD;
          end
        end else begin
          dir_raddr = walk_slot;
          state_nxt = S_CHKCMP;
        end
      end
      S_CHKCMP: begin
        if (!dir_rv_r || dir_rd_r != bkt_r) begin
          status_nxt = StatusFailed;
          state_nxt  = S_DONE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_CHKRD;
        end
      end
      // copy bucket contents into the held buffer
      S_CPYRD: begin
        if (j_r >= n_r) begin
          cnt_nxt   = '0;
          state_nxt = S_ASSIGN;
        end else begin
          state_nxt = S_CPYWR;
        end
      end
      S_CPYWR: begin
        held_we   = 1'b1;
        j_nxt     = j_r + 1'b1;
        state_nxt = S_CPYRD;
      end
      // give each shadow slot its own bucket, reset headers
      S_ASSIGN: begin
        if (cnt_r >= count) begin
          j_nxt     = '0;
          state_nxt = S_RDRD;
        end else begin
          hdr_we = 1'b1;
          if (cnt_r == '0) begin
            hdr_addr = bkt_r;
          end else begin
            hdr_addr  = BW'(alloc_r);
            dir_we    = 1'b1;
            dir_waddr = walk_slot;
            dir_wdata = BW'(alloc_r);
            alloc_nxt = alloc_r + 1'b1;
          end
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // redistribute held items by their keys
      S_RDRD: begin
        if (j_r >= n_r) begin
          guard_nxt = guard_r + 1'b1;
          state_nxt = S_DREAD;
        end else begin
          state_nxt = S_RDDIR;
        end
      end
      S_RDDIR: begin
        dir_raddr = hkey_rd_r[DW-1:0] & gmask;
        state_nxt = S_RDDIR2;
      end
      S_RDDIR2: begin
        hdr_addr  = dir_rd_r;
        idx_nxt   = DW'(dir_rd_r);
        if (dir_rv_r) begin
          state_nxt = S_RDFILL;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_RDRD;
        end
      end
      S_RDFILL: begin
        hdr_addr  = BW'(idx_r);
        state_nxt = S_RDAPP;
      end
      S_RDAPP: begin
        hdr_addr = BW'(idx_r);
        if (32'(fill_rd_r) < BUCKET_SLOTS) begin
          slot_we        = 1'b1;
          slot_waddr     = {BW'(idx_r), fill_rd_r[SW-1:0]};
          slot_wkey      = hkey_rd_r;
          slot_witem     = hitem_rd_r;
          fill_we        = 1'b1;
          hdr_fill_wdata = fill_rd_r + 1'b1;
        end
        j_nxt     = j_r + 1'b1;
        state_nxt = S_RDRD;
      end
      S_DONE: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gd_r    <= GW'(InitD);
      alloc_r <= '0;
    end else begin
      state_r <= state_nxt;
      gd_r    <= gd_nxt;
      alloc_r <= alloc_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      op_r   <= in_ch.operation;
      key_r  <= in_ch.hash_key;
      item_r <= ITEM_WIDTH'(in_ch.item_value);
    end
    status_r <= status_nxt;
    guard_r  <= guard_nxt;
    cnt_r    <= cnt_nxt;
    idx_r    <= idx_nxt;
    bkt_r    <= bkt_nxt;
    ld_r     <= ld_nxt;
    n_r      <= n_nxt;
    j_r      <= j_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = (state_r == S_DONE);
  assign out_ch.status        = status_r;
  assign out_ch.current_depth = DepthWidth'(gd_r);

`ifndef SYNTHESIS
  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(gd_r) <= MAX_DEPTH) else $error("global depth beyond maximum");
  a_pool: assert property (@(posedge clk) disable iff (!rst_n)
    32'(alloc_r) <= POOL_BUCKETS) else $error("bucket pool overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status))
    else $error("result changed before transfer");
  a_depth_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> gd_r >= $past(gd_r)) else $error("depth shrank");
`endif
endmodule

// ===== test/extendible_hash_table_unit_tb.sv =====
// Testbench for the extendible hash table unit: directed and random operations checked
// against a behavioral model of the table.
module extendible_hash_table_unit_tb;
  import eht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DirSlots = 1 << MaxDepthDef;

  typedef struct packed {
    logic                operation;
    logic [KeyWidth-1:0] hash_key;
    logic [31:0]         item_value;
  } op_req_t;

  typedef struct packed {
    status_t               status;
    logic [DepthWidth-1:0] current_depth;
  } op_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CapWidth-1:0] cfg_wdata = '0;

  eht_in_if  in_ch ();
  eht_out_if out_ch ();

  extendible_hash_table_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  // Model state of the table
  int unsigned dir_map [DirSlots];   // 0 empty, else bucket + 1
  int unsigned gdepth;
  int unsigned bkt_depth [PoolBucketsDef];
  int unsigned bkt_fill [PoolBucketsDef];
  logic [31:0] bkt_key [PoolBucketsDef*BucketSlotsDef];
  logic [31:0] bkt_item [PoolBucketsDef*BucketSlotsDef];
  int unsigned n_alloc;
  logic [CapWidth-1:0] capacity;

  op_req_t  pending_ops[$];
  op_resp_t expected_resps[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_send = 1'b0;

  // Predictor
  function automatic void table_clear();
    foreach (dir_map[i]) dir_map[i] = 0;
    gdepth = InitialDepthDef < MaxDepthDef ? InitialDepthDef : MaxDepthDef;
    n_alloc = 0;
    capacity = CapReset;
  endfunction

  function automatic int unsigned cap_limit();
    if (capacity < 1) return 1;
    if (capacity > BucketSlotsDef) return BucketSlotsDef;
    return capacity;
  endfunction

  function automatic void bucket_append(int unsigned b, logic [31:0] k, logic [31:0] v);
    int unsigned f;
    f = bkt_fill[b];
    if (f >= BucketSlotsDef) return;
    bkt_key[b*BucketSlotsDef+f] = k;
    bkt_item[b*BucketSlotsDef+f] = v;
    bkt_fill[b] = f + 1;
  endfunction

  function automatic bit bucket_split(int unsigned idx);
    logic [31:0] hk [BucketSlotsDef];
    logic [31:0] hv [BucketSlotsDef];
    int unsigned d, b, ld, stride, base, count, gmask, n, s, t;
    d = dir_map[idx];
    b = d - 1;
    ld = bkt_depth[b];
    stride = 1 << ld;
    base = idx & (stride - 1);
    count = 1 << (gdepth - ld);
    gmask = (1 << gdepth) - 1;
    for (int unsigned i = 1; i < count; i++)
      if (dir_map[base + i*stride] != d) return 1'b0;
    if (count - 1 > PoolBucketsDef - n_alloc) return 1'b0;
    n = bkt_fill[b] > BucketSlotsDef ? BucketSlotsDef : bkt_fill[b];
    for (int unsigned i = 0; i < n; i++) begin
      hk[i] = bkt_key[b*BucketSlotsDef+i];
      hv[i] = bkt_item[b*BucketSlotsDef+i];
    end
    for (int unsigned i = 0; i < count; i++) begin
      s = base + i*stride;
      if (i != 0) begin
        n_alloc++;
        dir_map[s] = n_alloc;
      end
      bkt_depth[dir_map[s]-1] = gdepth;
      bkt_fill[dir_map[s]-1] = 0;
    end
    for (int unsigned i = 0; i < n; i++) begin
      t = dir_map[hk[i] & gmask];
      if (t != 0) bucket_append(t - 1, hk[i], hv[i]);
    end
    return 1'b1;
  endfunction

  function automatic status_t table_insert(logic [31:0] k, logic [31:0] v);
    int unsigned idx, d, b, half;
    for (int guard = 0; guard < 2*MaxDepthDef + 4; guard++) begin
      idx = k & ((1 << gdepth) - 1);
      d = dir_map[idx];
      if (d == 0) begin
        if (n_alloc >= PoolBucketsDef) return StatusFailed;
        b = n_alloc;
        n_alloc++;
        bkt_depth[b] = gdepth;
        bkt_fill[b] = 0;
        dir_map[idx] = b + 1;
        bucket_append(b, k, v);
        return StatusInserted;
      end
      b = d - 1;
      if (bkt_fill[b] < cap_limit()) begin
        bucket_append(b, k, v);
        return StatusInserted;
      end
      if (bkt_depth[b] < gdepth) begin
        if (!bucket_split(idx)) return StatusFailed;
        continue;
      end
      if (gdepth >= MaxDepthDef) return StatusFailed;
      half = 1 << gdepth;
      for (int unsigned i = 0; i < half; i++) dir_map[i + half] = dir_map[i];
      gdepth++;
    end
    return StatusFailed;
  endfunction

  function automatic status_t table_lookup(logic [31:0] k, logic [31:0] v);
    int unsigned d, b, n;
    d = dir_map[k & ((1 << gdepth) - 1)];
    if (d == 0) return StatusMissing;
    b = d - 1;
    n = bkt_fill[b] > BucketSlotsDef ? BucketSlotsDef : bkt_fill[b];
    for (int unsigned i = 0; i < n; i++)
      if (bkt_item[b*BucketSlotsDef+i] == v) return StatusFound;
    return StatusMissing;
  endfunction

  function automatic op_resp_t table_apply(op_req_t r);
    op_resp_t o;
    o.status = (r.operation == OpQuery) ? table_lookup(r.hash_key, r.item_value)
                                        : table_insert(r.hash_key, r.item_value);
    o.current_depth = gdepth[DepthWidth-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Driver: one transfer per handshake, fed from pending_ops
  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OpInsert;
    in_ch.hash_key = '0;
    in_ch.item_value = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      logic fire;
      fire = in_ch.valid && in_ch.ready;
      if (fire) expected_resps.push_back(table_apply(
          op_req_t'{in_ch.operation, in_ch.hash_key, in_ch.item_value}));
      if (in_ch.valid && !fire) begin
        // hold until accepted
      end else if (pending_ops.size() > 0 && !hold_send &&
                   $urandom_range(99) >= send_idle_pct) begin
        op_req_t r;
        r = pending_ops.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.operation <= r.operation;
        in_ch.hash_key <= r.hash_key;
        in_ch.item_value <= r.item_value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_resps.size() == 0) begin
          report_mismatch("unexpected result", out_ch.status, 0);
        end else begin
          op_resp_t e;
          e = expected_resps.pop_front();
          if (out_ch.status !== e.status) report_mismatch("status", out_ch.status, e.status);
          if (out_ch.current_depth !== e.current_depth)
            report_mismatch("current_depth", out_ch.current_depth, e.current_depth);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic op_req_t mk(logic op, logic [31:0] k, logic [31:0] v);
    return op_req_t'{op, k, v};
  endfunction

  task automatic drain();
    while (pending_ops.size() > 0 || in_ch.valid || expected_resps.size() > 0)
      @(posedge clk);
  endtask

  task automatic drain_wait();
    while (in_ch.valid || expected_resps.size() > 0) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CapWidth-1:0] c);
    drain();
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity = c;
  endtask

  // Random phase: inserts and queries, about half reusing an earlier inserted key and item
  task automatic random_ops(int count, int keybits);
    logic [31:0] seen_k[$];
    logic [31:0] seen_v[$];
    logic [31:0] k, v;
    int j;
    for (int i = 0; i < count; i++) begin
      k = $urandom();
      v = $urandom();
      if (keybits < 32) k = k & ((32'd1 << keybits) - 1) | ($urandom() & 32'hFF00_0000);
      if (seen_k.size() > 0 && $urandom_range(99) < 50) begin
        j = $urandom_range(seen_k.size() - 1);
        k = seen_k[j];
        v = seen_v[j];
      end
      if ($urandom_range(99) < 55) begin
        pending_ops.push_back(mk(OpInsert, k, v));
        seen_k.push_back(k);
        seen_v.push_back(v);
      end else begin
        pending_ops.push_back(mk(OpQuery, k, v));
      end
    end
  endtask

  task automatic reset_table();
    table_clear();
  endtask

  // Stimulus
  initial begin
    table_clear();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty query, extremes, duplicates, full bucket to split and doubling
    pending_ops.push_back(mk(OpQuery, 32'h0, 32'h0));
    pending_ops.push_back(mk(OpInsert, 32'h0, 32'h0));
    pending_ops.push_back(mk(OpInsert, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_ops.push_back(mk(OpQuery, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_ops.push_back(mk(OpQuery, 32'h0, 32'h0));
    pending_ops.push_back(mk(OpQuery, 32'h0, 32'h1));
    pending_ops.push_back(mk(OpInsert, 32'h0, 32'h0));
    for (int i = 0; i < 8; i++)
      pending_ops.push_back(mk(OpInsert, 32'h4 * i, 32'h100 + i));
    for (int i = 0; i < 8; i++)
      pending_ops.push_back(mk(OpQuery, 32'h4 * i, 32'h100 + i));
    drain();

    // Min capacity: same key repeatedly, forces doubling to the maximum depth, then fails
    set_capacity(4'd0);
    for (int i = 0; i < 12; i++) pending_ops.push_back(mk(OpInsert, 32'h5, i));
    random_ops(40, 6);
    // pause sender until all results are in
    hold_send = 1'b1;
    repeat (5) @(posedge clk);
    drain_wait();
    hold_send = 1'b0;

    set_capacity(4'd15);
    send_idle_pct = 62;
    random_ops(100, 8);
    set_capacity(4'd8);
    send_idle_pct = 0;
    recv_stall_pct = 62;
    random_ops(100, 10);
    set_capacity(4'd1);
    send_idle_pct = 32;
    recv_stall_pct = 32;
    random_ops(100, 32);
    set_capacity(4'd3);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_ops(80, 5);
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS extendible_hash_table_unit");
    end else begin
      $display("FAIL extendible_hash_table_unit");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("FAIL extendible_hash_table_unit");
    $finish;
  end
endmodule

// ===== extendible_hash_table_unit.f =====
sv/eht_pkg.sv
sv/eht_if.sv
sv/extendible_hash_table_unit.sv
test/extendible_hash_table_unit_tb.sv
